// ===== hdl/lavm_pkg.sv =====
// ----------------------------------------------------------------------------
// lavm_pkg
// shared types, constants and fixed-point helpers of the look-at view matrix
// ----------------------------------------------------------------------------
package lavm_pkg;

    localparam int Q_ONE         = 65536;
    localparam int AXW           = 19;
    localparam int MW            = 50;
    localparam int IN_DEPTH_DEF  = 2;
    localparam int OUT_DEPTH_DEF = 4;

    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_FWD   = 2'd2;
    localparam logic [1:0] ROW_LAST  = 2'd3;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] upvec_x;
        logic signed [31:0] upvec_y;
        logic signed [31:0] upvec_z;
    } t_item;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] col0;
        logic signed [31:0] col1;
        logic signed [31:0] col2;
        logic signed [31:0] col3;
        logic               last_row;
    } t_row;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NLOAD,
        ST_NSHIFT,
        ST_NSQ,
        ST_NSQRT,
        ST_NDIVI,
        ST_NDIV,
        ST_CROSS,
        ST_UPV,
        ST_UPRND,
        ST_TRANS,
        ST_EMIT
    } t_state;

    // q32.32 to q16.16, halves away from zero
    function automatic logic signed [63:0] rnd_q16(input logic signed [63:0] x);
        logic [63:0] mag;
        logic [63:0] m;
        begin
            mag = x[63] ? 64'(-x) : 64'(x);
            m   = (mag + 64'd32768) >> 16;
            rnd_q16 = x[63] ? -$signed(m) : $signed(m);
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        begin
            hi = 64'sd2147483647;
            lo = -64'sd2147483648;
            if (x > hi) begin
                sat32 = 32'sh7fffffff;
            end else if (x < lo) begin
                sat32 = 32'sh80000000;
            end else begin
                sat32 = x[31:0];
            end
        end
    endfunction

endpackage

// ===== hdl/look_at_view_matrix.sv =====
// four rows out per request; the engine takes a new request from the input queue only after its last row is queued
// the square root (32 steps) and the divider (18 steps per component) run serially
// input queue holds IN_DEPTH requests, output queue OUT_DEPTH rows
// synchronous active-low reset empties both queues and idles the sequencer
// ----------------------------------------------------------------------------
// look_at_view_matrix
// fixed-point q16.16 look-at view matrix generator, one row per result
// ----------------------------------------------------------------------------
module look_at_view_matrix import lavm_pkg::*; #(
    parameter int IN_DEPTH  = IN_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_eye_x,
    input  logic signed [31:0] i_eye_y,
    input  logic signed [31:0] i_eye_z,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    input  logic signed [31:0] i_upvec_x,
    input  logic signed [31:0] i_upvec_y,
    input  logic signed [31:0] i_upvec_z,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_row_index,
    output logic signed [31:0] o_col0,
    output logic signed [31:0] o_col1,
    output logic signed [31:0] o_col2,
    output logic signed [31:0] o_col3,
    output logic               o_last_row
);

    t_item w_in;
    t_item w_item;
    logic  w_item_empty;
    logic  w_item_take;
    logic  w_row_push;
    logic  w_row_full;
    t_row  w_row;
    t_row  w_head;

    assign w_in.eye_x    = i_eye_x;
    assign w_in.eye_y    = i_eye_y;
    assign w_in.eye_z    = i_eye_z;
    assign w_in.target_x = i_target_x;
    assign w_in.target_y = i_target_y;
    assign w_in.target_z = i_target_z;
    assign w_in.upvec_x  = i_upvec_x;
    assign w_in.upvec_y  = i_upvec_y;
    assign w_in.upvec_z  = i_upvec_z;

    lavm_fifo #(.WIDTH($bits(t_item)), .DEPTH(IN_DEPTH)) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   (w_in),
        .o_full  (full),
        .i_pop   (w_item_take),
        .o_dout  (w_item),
        .o_empty (w_item_empty)
    );

    lavm_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (!w_item_empty),
        .i_item       (w_item),
        .o_item_take  (w_item_take),
        .o_row_push   (w_row_push),
        .o_row        (w_row),
        .i_row_full   (w_row_full)
    );

    lavm_fifo #(.WIDTH($bits(t_row)), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_row_push),
        .i_din   (w_row),
        .o_full  (w_row_full),
        .i_pop   (pop),
        .o_dout  (w_head),
        .o_empty (empty)
    );

    assign o_row_index = w_head.row_index;
    assign o_col0      = w_head.col0;
    assign o_col1      = w_head.col1;
    assign o_col2      = w_head.col2;
    assign o_col3      = w_head.col3;
    assign o_last_row  = w_head.last_row;

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_row_push |-> !w_row_full)
        else $error("row written into full output queue");

    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_row_index != ROW_LAST) |=>
        (empty || o_row_index == $past(o_row_index) + 2'd1))
        else $error("rows out of order");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_last_row == (o_row_index == ROW_LAST)))
        else $error("last row flag mismatch");

endmodule

// ===== hdl/lavm_fifo.sv =====
// ----------------------------------------------------------------------------
// lavm_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module lavm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_din,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_dout,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_dout  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_din;
        end
    end

endmodule

// ===== hdl/lavm_engine.sv =====
// ----------------------------------------------------------------------------
// lavm_engine
// back end: sequencer with one shared multiplier, serial sqrt and divider
// ----------------------------------------------------------------------------
module lavm_engine import lavm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_item_valid,
    input  t_item i_item,
    output logic  o_item_take,
    output logic  o_row_push,
    output t_row  o_row,
    input  logic  i_row_full
);

    t_state r_state, n_state;

    logic signed [31:0]    r_eye [3];
    logic signed [31:0]    r_up  [3];
    logic signed [AXW-1:0] r_ax  [3][3];
    logic signed [63:0]    r_acc [3];
    logic [MW-1:0]         r_m   [3];
    logic [2:0]            r_neg;
    logic                  r_pass;
    logic [3:0]            r_step;
    logic [1:0]            r_row;
    logic [1:0]            r_comp;
    logic [63:0]           r_bit;
    logic [63:0]           r_root;
    logic [30:0]           r_len;
    logic [30:0]           r_rem;
    logic [17:0]           r_lo;
    logic [17:0]           r_q;
    logic [4:0]            r_cnt;
    logic signed [65:0]    r_prod;
    logic                  r_mv;
    logic [1:0]            r_midx;
    logic                  r_mneg;

    logic                  n_mv;
    logic [1:0]            n_midx;
    logic                  n_mneg;
    logic signed [32:0]    n_ma;
    logic signed [32:0]    n_mb;

    logic [MW-1:0]         m_or;
    logic                  m_zero;
    logic                  m_hi;
    logic                  m_lo;
    logic [63:0]           sq_rb;
    logic                  sq_ge;
    logic [63:0]           n_root;
    logic [31:0]           dv_t;
    logic                  dv_ge;
    logic [31:0]           dv_sub;
    logic [46:0]           dv_num;
    logic [17:0]           dv_q;
    logic [1:0]            wrow;
    logic [1:0]            pj;
    logic [1:0]            ia;
    logic [1:0]            ib;
    logic [1:0]            trow;
    logic [1:0]            tcomp;
    logic                  last_cnt;

    function automatic logic [1:0] nx1(input logic [1:0] j);
        nx1 = (j == 2'd2) ? 2'd0 : j + 2'd1;
    endfunction

    function automatic logic [1:0] nx2(input logic [1:0] j);
        nx2 = (j == 2'd0) ? 2'd2 : j - 2'd1;
    endfunction

    assign m_or   = r_m[0] | r_m[1] | r_m[2];
    assign m_zero = (m_or == '0);
    assign m_hi   = |m_or[MW-1:30];
    assign m_lo   = (m_or[MW-1:29] == '0);
    assign sq_rb  = r_root + r_bit;
    assign sq_ge  = 64'(r_acc[0]) >= sq_rb;
    assign n_root = sq_ge ? (r_root >> 1) + r_bit : r_root >> 1;
    assign dv_t   = {r_rem, r_lo[17]};
    assign dv_ge  = dv_t >= {1'b0, r_len};
    assign dv_sub = dv_t - {1'b0, r_len};
    assign dv_num = {1'b0, r_m[r_comp][29:0], 16'b0} + 47'(r_len >> 1);
    assign dv_q   = {r_q[16:0], dv_ge};
    assign wrow   = r_pass ? ROW_RIGHT : ROW_FWD;
    assign pj     = r_step[2:1];
    assign ia     = r_step[0] ? nx2(pj) : nx1(pj);
    assign ib     = r_step[0] ? nx1(pj) : nx2(pj);
    assign trow   = (r_step < 4'd3) ? 2'd0 : (r_step < 4'd6) ? 2'd1 : 2'd2;
    assign tcomp  = (r_step < 4'd3) ? r_step[1:0] :
                    (r_step < 4'd6) ? 2'(r_step - 4'd3) : 2'(r_step - 4'd6);
    assign last_cnt = (r_cnt == 5'd17);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_item_valid) n_state = ST_NLOAD;
            end
            ST_NLOAD: begin
                n_state = ST_NSHIFT;
            end
            ST_NSHIFT: begin
                if (m_zero) begin
                    n_state = r_pass ? ST_UPV : ST_CROSS;
                end else if (!m_hi && !m_lo) begin
                    n_state = ST_NSQ;
                end
            end
            ST_NSQ: begin
                if (r_step == 4'd3) n_state = ST_NSQRT;
            end
            ST_NSQRT: begin
                if (r_bit[0]) n_state = ST_NDIVI;
            end
            ST_NDIVI: begin
                n_state = ST_NDIV;
            end
            ST_NDIV: begin
                if (last_cnt) begin
                    if (r_comp == 2'd2) begin
                        n_state = r_pass ? ST_UPV : ST_CROSS;
                    end else begin
                        n_state = ST_NDIVI;
                    end
                end
            end
            ST_CROSS: begin
                if (r_step == 4'd6) n_state = ST_NLOAD;
            end
            ST_UPV: begin
                if (r_step == 4'd6) n_state = ST_UPRND;
            end
            ST_UPRND: begin
                n_state = ST_TRANS;
            end
            ST_TRANS: begin
                if (r_step == 4'd9) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_row_full && r_row == ROW_LAST) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and multiplier issue
    always_comb begin
        n_mv   = 1'b0;
        n_midx = 2'd0;
        n_mneg = 1'b0;
        n_ma   = '0;
        n_mb   = '0;
        case (r_state)
            ST_NSQ: begin
                if (r_step < 4'd3) begin
                    n_mv = 1'b1;
                    n_ma = $signed({3'b0, r_m[r_step[1:0]][29:0]});
                    n_mb = n_ma;
                end
            end
            ST_CROSS: begin
                if (r_step < 4'd6) begin
                    n_mv   = 1'b1;
                    n_midx = pj;
                    n_mneg = r_step[0];
                    n_ma   = 33'(r_up[ia]);
                    n_mb   = 33'(r_ax[ROW_FWD][ib]);
                end
            end
            ST_UPV: begin
                if (r_step < 4'd6) begin
                    n_mv   = 1'b1;
                    n_midx = pj;
                    n_mneg = r_step[0];
                    n_ma   = 33'(r_ax[ROW_FWD][ia]);
                    n_mb   = 33'(r_ax[ROW_RIGHT][ib]);
                end
            end
            ST_TRANS: begin
                if (r_step < 4'd9) begin
                    n_mv   = 1'b1;
                    n_midx = trow;
                    n_ma   = 33'(r_ax[trow][tcomp]);
                    n_mb   = 33'(r_eye[tcomp]);
                end
            end
            default: begin
            end
        endcase

        o_item_take = (r_state == ST_IDLE) && i_item_valid;
        o_row_push  = (r_state == ST_EMIT) && !i_row_full;

        o_row.row_index = r_row;
        o_row.last_row  = (r_row == ROW_LAST);
        o_row.col0      = '0;
        o_row.col1      = '0;
        o_row.col2      = '0;
        o_row.col3      = 32'(Q_ONE);
        if (r_row != ROW_LAST) begin
            o_row.col0 = 32'(r_ax[r_row][0]);
            o_row.col1 = 32'(r_ax[r_row][1]);
            o_row.col2 = 32'(r_ax[r_row][2]);
            o_row.col3 = sat32(rnd_q16(-r_acc[r_row]));
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mv    <= 1'b0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_mv    <= n_mv;
            r_step  <= (n_state != r_state) ? 4'd0 : r_step + 4'd1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= n_ma * n_mb;
        r_midx <= n_midx;
        r_mneg <= n_mneg;
        case (r_state)
            ST_IDLE: begin
                if (o_item_take) begin
                    r_eye[0] <= i_item.eye_x;
                    r_eye[1] <= i_item.eye_y;
                    r_eye[2] <= i_item.eye_z;
                    r_up[0]  <= i_item.upvec_x;
                    r_up[1]  <= i_item.upvec_y;
                    r_up[2]  <= i_item.upvec_z;
                    r_acc[0] <= 64'(33'(i_item.target_x) - 33'(i_item.eye_x));
                    r_acc[1] <= 64'(33'(i_item.target_y) - 33'(i_item.eye_y));
                    r_acc[2] <= 64'(33'(i_item.target_z) - 33'(i_item.eye_z));
                    r_pass   <= 1'b0;
                end
            end
            ST_NLOAD: begin
                for (int i = 0; i < 3; i++) begin
                    r_neg[i] <= r_acc[i][63];
                    r_m[i]   <= r_acc[i][63] ? MW'(-r_acc[i]) : MW'(r_acc[i]);
                end
                r_comp <= 2'd0;
            end
            ST_NSHIFT: begin
                if (m_zero) begin
                    for (int i = 0; i < 3; i++) r_ax[wrow][i] <= '0;
                end else if (m_hi) begin
                    for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                end else if (m_lo) begin
                    for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                end else begin
                    for (int i = 0; i < 3; i++) r_acc[i] <= '0;
                    r_bit  <= 64'd1 << 62;
                    r_root <= '0;
                end
            end
            ST_NSQRT: begin
                if (sq_ge) r_acc[0] <= $signed(64'(r_acc[0]) - sq_rb);
                r_root <= n_root;
                r_bit  <= r_bit >> 2;
                if (r_bit[0]) r_len <= n_root[30:0];
            end
            ST_NDIVI: begin
                r_rem <= 31'(dv_num[46:18]);
                r_lo  <= dv_num[17:0];
                r_q   <= '0;
                r_cnt <= '0;
            end
            ST_NDIV: begin
                r_rem <= dv_ge ? dv_sub[30:0] : dv_t[30:0];
                r_lo  <= r_lo << 1;
                r_q   <= dv_q;
                r_cnt <= r_cnt + 5'd1;
                if (last_cnt) begin
                    r_ax[wrow][r_comp] <= r_neg[r_comp] ? -$signed({1'b0, dv_q})
                                                        : $signed({1'b0, dv_q});
                    r_comp <= r_comp + 2'd1;
                end
            end
            ST_CROSS: begin
                if (r_step == 4'd0) begin
                    for (int i = 0; i < 3; i++) r_acc[i] <= '0;
                end
                if (r_step == 4'd6) r_pass <= 1'b1;
            end
            ST_UPV: begin
                if (r_step == 4'd0) begin
                    for (int i = 0; i < 3; i++) r_acc[i] <= '0;
                end
            end
            ST_UPRND: begin
                for (int i = 0; i < 3; i++) r_ax[ROW_UP][i] <= AXW'(rnd_q16(r_acc[i]));
            end
            ST_TRANS: begin
                if (r_step == 4'd0) begin
                    for (int i = 0; i < 3; i++) r_acc[i] <= '0;
                end
                r_row <= ROW_RIGHT;
            end
            ST_EMIT: begin
                if (o_row_push) r_row <= r_row + 2'd1;
            end
            default: begin
            end
        endcase
        if (r_mv) begin
            r_acc[r_midx] <= r_acc[r_midx] + (r_mneg ? -64'(r_prod) : 64'(r_prod));
        end
    end

endmodule

// ===== tb/lavm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lavm_checker
// watches the request and row channels of the look-at view matrix, predicts
// the four rows of every accepted request and compares them field by field
// ----------------------------------------------------------------------------
module lavm_checker import lavm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  t_item              i_item,
    input  logic               i_empty,
    input  logic               i_pop,
    input  t_row               i_row,
    output int                 o_fail_count,
    output int                 o_pending
);

    t_row rows_due[$];

    function automatic logic [63:0] mag_of(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] round_to_q16(input logic signed [63:0] x);
        logic [63:0] m;
        m = (mag_of(x) + 64'd32768) >> 16;
        return x < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    task automatic unit_vec(input logic signed [63:0] v[3], output logic signed [63:0] o[3]);
        logic [63:0] m[3];
        logic [63:0] mx;
        logic [63:0] len;
        logic [63:0] q;
        for (int i = 0; i < 3; i++) m[i] = mag_of(v[i]);
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        if (mx == 0) begin
            for (int i = 0; i < 3; i++) o[i] = 0;
            return;
        end
        while (mx >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            mx = mx << 1;
        end
        len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * 64'd65536 + len / 2) / len;
            o[i] = v[i] < 0 ? -$signed(q) : $signed(q);
        end
    endtask

    function automatic logic signed [31:0] shift_term(input logic signed [63:0] a[3],
                                                      input logic signed [63:0] e[3]);
        return clamp32(round_to_q16(-(a[0] * e[0] + a[1] * e[1] + a[2] * e[2])));
    endfunction

    task automatic predict_view_rows(input t_item it);
        logic signed [63:0] eye[3];
        logic signed [63:0] tgt[3];
        logic signed [63:0] up[3];
        logic signed [63:0] d[3];
        logic signed [63:0] f[3];
        logic signed [63:0] cr[3];
        logic signed [63:0] r[3];
        logic signed [63:0] u[3];
        eye[0] = it.eye_x; eye[1] = it.eye_y; eye[2] = it.eye_z;
        tgt[0] = it.target_x; tgt[1] = it.target_y; tgt[2] = it.target_z;
        up[0] = it.upvec_x; up[1] = it.upvec_y; up[2] = it.upvec_z;
        for (int i = 0; i < 3; i++) d[i] = tgt[i] - eye[i];
        unit_vec(d, f);
        cr[0] = up[1] * f[2] - up[2] * f[1];
        cr[1] = up[2] * f[0] - up[0] * f[2];
        cr[2] = up[0] * f[1] - up[1] * f[0];
        unit_vec(cr, r);
        u[0] = round_to_q16(f[1] * r[2] - f[2] * r[1]);
        u[1] = round_to_q16(f[2] * r[0] - f[0] * r[2]);
        u[2] = round_to_q16(f[0] * r[1] - f[1] * r[0]);
        rows_due.push_back('{ROW_RIGHT, r[0][31:0], r[1][31:0], r[2][31:0],
                             shift_term(r, eye), 1'b0});
        rows_due.push_back('{ROW_UP, u[0][31:0], u[1][31:0], u[2][31:0],
                             shift_term(u, eye), 1'b0});
        rows_due.push_back('{ROW_FWD, f[0][31:0], f[1][31:0], f[2][31:0],
                             shift_term(f, eye), 1'b0});
        rows_due.push_back('{ROW_LAST, 32'sd0, 32'sd0, 32'sd0, 32'sd65536, 1'b1});
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_row w;
        if (i_rst_n) begin
            if (i_pop && !i_empty) begin
                if (rows_due.size() == 0) begin
                    report("unexpected row", i_row.col0, 0);
                end else begin
                    w = rows_due.pop_front();
                    if (i_row.row_index !== w.row_index) report("row_index", i_row.row_index, w.row_index);
                    if (i_row.col0 !== w.col0) report("col0", i_row.col0, w.col0);
                    if (i_row.col1 !== w.col1) report("col1", i_row.col1, w.col1);
                    if (i_row.col2 !== w.col2) report("col2", i_row.col2, w.col2);
                    if (i_row.col3 !== w.col3) report("col3", i_row.col3, w.col3);
                    if (i_row.last_row !== w.last_row) report("last_row", i_row.last_row, w.last_row);
                end
            end
            if (i_push && !i_full) predict_view_rows(i_item);
        end
        o_pending = rows_due.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// directed and random look-at requests with random gaps and stalls on both
// sides; the checker predicts and compares every row
// ----------------------------------------------------------------------------
module tb_top import lavm_pkg::*; ();

    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 110;

    logic  i_clk = 0;
    logic  i_rst_n = 0;
    logic  push = 0;
    logic  pop = 0;
    logic  full;
    logic  empty;
    t_item req = '0;
    t_row  row;
    int    fail_count;
    int    pending;
    int    idle_cycles = 0;
    int    n_sent = 0;

    always #5 i_clk = ~i_clk;

    look_at_view_matrix u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_eye_x(req.eye_x), .i_eye_y(req.eye_y), .i_eye_z(req.eye_z),
        .i_target_x(req.target_x), .i_target_y(req.target_y), .i_target_z(req.target_z),
        .i_upvec_x(req.upvec_x), .i_upvec_y(req.upvec_y), .i_upvec_z(req.upvec_z),
        .empty(empty), .pop(pop), .o_row_index(row.row_index), .o_col0(row.col0),
        .o_col1(row.col1), .o_col2(row.col2), .o_col3(row.col3), .o_last_row(row.last_row)
    );

    lavm_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_full(full), .i_item(req),
        .i_empty(empty), .i_pop(pop), .i_row(row),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 400);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 4);
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $signed($urandom_range(0, 20)) * 32'sd65536 - 32'sd655360;
            2: return 32'sh7fffffff;
            3: return 32'sh80000000;
            default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
        endcase
    endfunction

    // leaves push high on return; the next call or the caller drops it
    task automatic send(input t_item it);
        int g;
        g = gap_len();
        if (g != 0) begin
            push <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        req  <= it;
        push <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
        n_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic send_random();
        t_item it;
        it.eye_x = rand_coord(); it.eye_y = rand_coord(); it.eye_z = rand_coord();
        it.target_x = rand_coord(); it.target_y = rand_coord(); it.target_z = rand_coord();
        it.upvec_x = rand_coord(); it.upvec_y = rand_coord(); it.upvec_z = rand_coord();
        case ($urandom_range(0, 9))
            0: begin
                it.target_x = it.eye_x; it.target_y = it.eye_y; it.target_z = it.eye_z;
            end
            1: begin
                it.upvec_x = it.target_x - it.eye_x;
                it.upvec_y = it.target_y - it.eye_y;
                it.upvec_z = it.target_z - it.eye_z;
            end
            2: begin
                it.upvec_x = 0; it.upvec_y = 0; it.upvec_z = 0;
            end
            default: ;
        endcase
        send(it);
    endtask

    // row side: random stalls
    initial begin
        int s;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            s = gap_len();
            if (s != 0) begin
                pop <= 1'b0;
                repeat (s) @(negedge i_clk);
            end
            pop <= 1'b1;
            @(negedge i_clk);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        t_item it;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // plain view along -z, y up
        it = '{32'sd0, 32'sd0, 32'sd327680, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0};
        send(it);
        // eye equal to target
        it = '{32'sd65536, -32'sd65536, 32'sd131072, 32'sd65536, -32'sd65536, 32'sd131072,
               32'sd0, 32'sd65536, 32'sd0};
        send(it);
        // up parallel to forward, and zero up
        it = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd655360, 32'sd0, 32'sd0, 32'sd65536, 32'sd0};
        send(it);
        it.upvec_y = 0;
        send(it);
        // extremes, large translations
        it = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
               32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
        send(it);
        it = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
               32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000};
        send(it);
        it = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
               32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
        send(it);
        it = '{-32'sd1, -32'sd1, -32'sd1, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sd1};
        send(it);
        it = '{32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555,
               32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555};
        send(it);
        // hold off until all rows are drained
        drain();
        for (int k = 0; k < N_RANDOM; k++) begin
            send_random();
            if (k == N_RANDOM / 2) begin
                drain();
            end
        end
        drain();
        repeat (300) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
